/* hdl/stsb_pkg.sv */
// Package for the soft timer slot bank: request/result structs, operation,
// status and sequencer codes. No dependencies.
`timescale 1ns / 1ps

package stsb_pkg;

  localparam int unsigned NumSlotsDefault = 5;
  localparam int unsigned CountW = 32;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_REGISTER   = 3'd1,
    OP_UNREGISTER = 3'd2,
    OP_UPDATE     = 3'd3,
    OP_CHECK      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        slot;
    logic [CountW-1:0] period;
    logic [CountW-1:0] start_stamp;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              fired;
    logic [2:0]        fired_slot;
    logic              elapsed;
    logic [CountW-1:0] count_now;
    logic              last;
  } rsp_t;

endpackage

/* hdl/stsb_age_unit.sv */
// Shared age comparator: reports whether (now - stamp) mod 2^32 exceeds a limit.
// Depends on stsb_pkg.
`timescale 1ns / 1ps

module stsb_age_unit (
  input  logic [stsb_pkg::CountW-1:0] now_i,
  input  logic [stsb_pkg::CountW-1:0] stamp_i,
  input  logic [stsb_pkg::CountW-1:0] limit_i,
  output logic                        expired_o
);

  logic [stsb_pkg::CountW-1:0] age;

  // The subtraction wraps naturally at the counter width.
  assign age       = now_i - stamp_i;
  assign expired_o = (age > limit_i);

endmodule

/* hdl/stsb_slot_bank.sv */
// Slot storage: active flag, start stamp and period per slot, one write and
// one read port, plus a lowest-free-slot finder. Depends on stsb_pkg.
`timescale 1ns / 1ps

module stsb_slot_bank #(
  parameter int unsigned NUM_SLOTS = stsb_pkg::NumSlotsDefault,
  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_active_i,
  input  logic                        we_start_i,
  input  logic                        we_period_i,
  input  logic [IdxW-1:0]             wr_idx_i,
  input  logic                        wr_active_i,
  input  logic [stsb_pkg::CountW-1:0] wr_start_i,
  input  logic [stsb_pkg::CountW-1:0] wr_period_i,
  input  logic [IdxW-1:0]             rd_idx_i,
  output logic                        rd_active_o,
  output logic [stsb_pkg::CountW-1:0] rd_start_o,
  output logic [stsb_pkg::CountW-1:0] rd_period_o,
  output logic                        free_found_o,
  output logic [IdxW-1:0]             free_idx_o
);

  logic [NUM_SLOTS-1:0]        active_q;
  logic [stsb_pkg::CountW-1:0] start_q  [NUM_SLOTS];
  logic [stsb_pkg::CountW-1:0] period_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        start_q[i]  <= '0;
        period_q[i] <= '0;
      end
    end else begin
      if (we_active_i) begin
        active_q[wr_idx_i] <= wr_active_i;
      end
      if (we_start_i) begin
        start_q[wr_idx_i] <= wr_start_i;
      end
      if (we_period_i) begin
        period_q[wr_idx_i] <= wr_period_i;
      end
    end
  end

  assign rd_active_o = active_q[rd_idx_i];
  assign rd_start_o  = start_q[rd_idx_i];
  assign rd_period_o = period_q[rd_idx_i];

  // Walk downward so the lowest free index wins.
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = IdxW'(i);
      end
    end
  end

endmodule

/* hdl/soft_timer_slot_bank.sv */
// Top level of the soft timer slot bank: sequencer, tick counter and result
// register. Depends on stsb_pkg, stsb_slot_bank and stsb_age_unit.
`timescale 1ns / 1ps
//
// Usage: a request (req_i) is taken at a clock edge with start high and busy
// low. Each result appears on rsp_o for exactly one cycle with done_o high;
// the receiver cannot stall, so every result must be taken as it appears.
// The final result of a request has rsp_o.last set.
// Sequence: register, unregister, update, check and unused codes occupy the
// block for the execute state after acceptance; the result is registered there,
// and the next request can be accepted in the same cycle that the result shows.
// A tick increments the counter at acceptance, then one shared age comparator
// visits one slot per cycle in the scan state, followed by the closing finish
// state, and busy stays high through both states.
// Fired results stream out during the scan, each registered as the next firing
// slot is found; the final one (or the no-expiry result) comes last.
// Reset clears the counter, all slot active flags and any pending result.
//
module soft_timer_slot_bank #(
  parameter int unsigned NUM_SLOTS = stsb_pkg::NumSlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  stsb_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output stsb_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CountW = stsb_pkg::CountW;

  stsb_pkg::state_e   state_q, state_d;
  stsb_pkg::req_t     req_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [IdxW-1:0]    pend_slot_q, pend_slot_d;
  logic               done_q, done_d;
  stsb_pkg::rsp_t     rsp_q, rsp_d;

  logic               accept;
  logic               idx_last;
  logic               slot_in_range;

  logic               we_active, we_start, we_period;
  logic [IdxW-1:0]    wr_idx;
  logic               wr_active;
  logic [CountW-1:0]  wr_start, wr_period;
  logic               rd_active;
  logic [CountW-1:0]  rd_start, rd_period;
  logic               free_found;
  logic [IdxW-1:0]    free_idx;

  logic [CountW-1:0]  age_stamp, age_limit;
  logic               expired;

  assign busy     = (state_q != stsb_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign idx_last = (idx_q == IdxW'(NUM_SLOTS - 1));
  assign slot_in_range = ({1'b0, req_q.slot} < 4'(NUM_SLOTS));

  stsb_slot_bank #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_active_i (we_active),
    .we_start_i  (we_start),
    .we_period_i (we_period),
    .wr_idx_i    (wr_idx),
    .wr_active_i (wr_active),
    .wr_start_i  (wr_start),
    .wr_period_i (wr_period),
    .rd_idx_i    (idx_q),
    .rd_active_o (rd_active),
    .rd_start_o  (rd_start),
    .rd_period_o (rd_period),
    .free_found_o(free_found),
    .free_idx_o  (free_idx)
  );

  stsb_age_unit u_age (
    .now_i    (count_q),
    .stamp_i  (age_stamp),
    .limit_i  (age_limit),
    .expired_o(expired)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stsb_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (stsb_pkg::op_e'(req_i.op) == stsb_pkg::OP_TICK) ?
                    stsb_pkg::S_SCAN : stsb_pkg::S_EXEC;
        end
      end
      stsb_pkg::S_EXEC:   state_d = stsb_pkg::S_IDLE;
      stsb_pkg::S_SCAN: begin
        if (idx_last) begin
          state_d = stsb_pkg::S_FINISH;
        end
      end
      stsb_pkg::S_FINISH: state_d = stsb_pkg::S_IDLE;
      default:            state_d = stsb_pkg::S_IDLE;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    we_active   = 1'b0;
    we_start    = 1'b0;
    we_period   = 1'b0;
    wr_idx      = idx_q;
    wr_active   = 1'b0;
    wr_start    = count_q;
    wr_period   = req_q.period;
    age_stamp   = rd_start;
    age_limit   = rd_period;

    unique case (state_q)
      stsb_pkg::S_IDLE: begin
        if (accept) begin
          idx_d  = '0;
          pend_d = 1'b0;
          if (stsb_pkg::op_e'(req_i.op) == stsb_pkg::OP_TICK) begin
            count_d = count_q + 1'b1;
          end
        end
      end

      stsb_pkg::S_EXEC: begin
        done_d           = 1'b1;
        rsp_d            = '0;
        rsp_d.status     = stsb_pkg::STATUS_OK;
        rsp_d.count_now  = count_q;
        rsp_d.last       = 1'b1;
        age_stamp        = req_q.start_stamp;
        age_limit        = req_q.period;
        unique case (stsb_pkg::op_e'(req_q.op))
          stsb_pkg::OP_REGISTER: begin
            if (free_found) begin
              we_active        = 1'b1;
              we_start         = 1'b1;
              we_period        = 1'b1;
              wr_idx           = free_idx;
              wr_active        = 1'b1;
              rsp_d.fired_slot = 3'(free_idx);
            end else begin
              rsp_d.status = stsb_pkg::STATUS_NO_FREE;
            end
          end
          stsb_pkg::OP_UNREGISTER: begin
            if (slot_in_range) begin
              we_active = 1'b1;
              we_start  = 1'b1;
              we_period = 1'b1;
              wr_idx    = req_q.slot[IdxW-1:0];
              wr_start  = '0;
              wr_period = '0;
            end else begin
              rsp_d.status = stsb_pkg::STATUS_RANGE;
            end
          end
          stsb_pkg::OP_UPDATE: begin
            if (slot_in_range) begin
              we_start  = 1'b1;
              we_period = 1'b1;
              wr_idx    = req_q.slot[IdxW-1:0];
            end else begin
              rsp_d.status = stsb_pkg::STATUS_RANGE;
            end
          end
          stsb_pkg::OP_CHECK: begin
            rsp_d.elapsed = expired;
          end
          default: begin
          end
        endcase
      end

      stsb_pkg::S_SCAN: begin
        if (!idx_last) begin
          idx_d = idx_q + 1'b1;
        end
        if (rd_active && expired) begin
          we_start = 1'b1;
          wr_idx   = idx_q;
          // A new firing means the held one is not the final result.
          if (pend_q) begin
            done_d           = 1'b1;
            rsp_d            = '0;
            rsp_d.status     = stsb_pkg::STATUS_OK;
            rsp_d.fired      = 1'b1;
            rsp_d.fired_slot = 3'(pend_slot_q);
            rsp_d.count_now  = count_q;
          end
          pend_d      = 1'b1;
          pend_slot_d = idx_q;
        end
      end

      stsb_pkg::S_FINISH: begin
        done_d          = 1'b1;
        rsp_d           = '0;
        rsp_d.status    = stsb_pkg::STATUS_OK;
        rsp_d.count_now = count_q;
        rsp_d.last      = 1'b1;
        if (pend_q) begin
          rsp_d.fired      = 1'b1;
          rsp_d.fired_slot = 3'(pend_slot_q);
        end
        pend_d = 1'b0;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stsb_pkg::S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    pend_slot_q <= pend_slot_d;
    rsp_q       <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* test/tb_soft_timer_slot_bank.sv */
// Self-checking testbench for soft_timer_slot_bank: a queue-fed driver, a result
// monitor and a predictor of the tick counter and slot bank. Depends on stsb_pkg.
`timescale 1ns / 1ps

module tb_soft_timer_slot_bank;

  localparam int unsigned NUM_SLOTS = stsb_pkg::NumSlotsDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomRequests = 350;
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct {
    stsb_pkg::req_t req;
    int unsigned    gap;
    bit             drain;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  stsb_pkg::req_t req_i = '0;
  logic busy;
  logic done_o;
  stsb_pkg::rsp_t rsp_o;

  soft_timer_slot_bank #(.NUM_SLOTS(NUM_SLOTS)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // Predicted timer state.
  logic [31:0] tick_now = '0;
  logic        slot_active [NUM_SLOTS];
  logic [31:0] slot_start [NUM_SLOTS];
  logic [31:0] slot_period [NUM_SLOTS];

  stim_t          request_q[$];
  stsb_pkg::rsp_t rsp_due_q[$];
  stim_t          cur_item;
  bit             holding = 1'b0;
  bit             next_start;
  int unsigned    gap_left = 0;
  int unsigned    results_due = 0;
  int unsigned    results_seen = 0;
  int unsigned    error_count = 0;
  int unsigned    fired_total = 0;
  int unsigned    op_count [8];
  int unsigned    cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at result %0d, %s: got %0h, want %0h", results_seen, what, got,
             want);
    error_count++;
  endtask

  // Works out the results of one accepted request and advances the state.
  task automatic predict_request(input stsb_pkg::req_t r);
    stsb_pkg::rsp_t held;
    stsb_pkg::rsp_t rsp;
    bit   have_held;
    int   free_slot;
    have_held = 1'b0;
    free_slot = -1;
    held = '0;
    rsp = '0;
    op_count[r.op]++;
    case (r.op)
      stsb_pkg::OP_TICK: begin
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_active[i] && (tick_now - slot_start[i]) > slot_period[i]) begin
            slot_start[i] = tick_now;
            if (have_held) begin
              rsp_due_q.push_back(held);
              results_due++;
            end
            held = '0;
            held.fired = 1'b1;
            held.fired_slot = 3'(i);
            held.count_now = tick_now;
            have_held = 1'b1;
            fired_total++;
          end
        end
        if (have_held) rsp = held;
      end
      stsb_pkg::OP_REGISTER: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_active[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          rsp.status = stsb_pkg::STATUS_NO_FREE;
        end else begin
          slot_active[free_slot] = 1'b1;
          slot_start[free_slot] = tick_now;
          slot_period[free_slot] = r.period;
          rsp.fired_slot = 3'(free_slot);
        end
      end
      stsb_pkg::OP_UNREGISTER: begin
        if (r.slot >= NUM_SLOTS) begin
          rsp.status = stsb_pkg::STATUS_RANGE;
        end else begin
          slot_active[r.slot] = 1'b0;
          slot_start[r.slot] = '0;
          slot_period[r.slot] = '0;
        end
      end
      stsb_pkg::OP_UPDATE: begin
        if (r.slot >= NUM_SLOTS) begin
          rsp.status = stsb_pkg::STATUS_RANGE;
        end else begin
          // An inactive slot takes the new values but stays inactive.
          slot_start[r.slot] = tick_now;
          slot_period[r.slot] = r.period;
        end
      end
      stsb_pkg::OP_CHECK: begin
        rsp.elapsed = ((tick_now - r.start_stamp) > r.period);
      end
      default: begin
      end
    endcase
    rsp.count_now = tick_now;
    rsp.last = 1'b1;
    rsp_due_q.push_back(rsp);
    results_due++;
  endtask

  // Driver: holds each request until it is taken, then waits out the gap
  // (and, when asked, every outstanding result) before the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else if (start && busy) begin
      // The request is still waiting for the block.
    end else begin
      if (start) predict_request(req_i);
      next_start = 1'b0;
      if (!holding && request_q.size() != 0) begin
        cur_item = request_q.pop_front();
        gap_left = cur_item.gap;
        holding = 1'b1;
      end
      if (holding) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!cur_item.drain || results_due == results_seen) begin
          next_start = 1'b1;
          holding = 1'b0;
          req_i <= cur_item.req;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked at once.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (rsp_due_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(rsp_o), '0);
      end else begin
        stsb_pkg::rsp_t want;
        want = rsp_due_q.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch("status", 32'(rsp_o.status), 32'(want.status));
        if (rsp_o.fired !== want.fired)
          report_mismatch("fired", 32'(rsp_o.fired), 32'(want.fired));
        if (rsp_o.fired_slot !== want.fired_slot)
          report_mismatch("fired_slot", 32'(rsp_o.fired_slot), 32'(want.fired_slot));
        if (rsp_o.elapsed !== want.elapsed)
          report_mismatch("elapsed", 32'(rsp_o.elapsed), 32'(want.elapsed));
        if (rsp_o.count_now !== want.count_now)
          report_mismatch("count_now", rsp_o.count_now, want.count_now);
        if (rsp_o.last !== want.last)
          report_mismatch("last", 32'(rsp_o.last), 32'(want.last));
        results_seen <= results_seen + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               rsp_due_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_period();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 8);
    if (roll < 85) return $urandom();
    return (roll < 92) ? 32'd0 : AllOnes;
  endfunction

  function automatic logic [31:0] pick_stamp();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(0, 400);
    if (roll < 80) return $urandom();
    // Stamps just below the wrap point age through the modulo.
    return AllOnes - $urandom_range(0, 3);
  endfunction

  task automatic add_request(input logic [2:0] op, input logic [2:0] slot,
                             input logic [31:0] period, input logic [31:0] stamp,
                             input bit quiet, input bit drain);
    stim_t s;
    s.req.op = op;
    s.req.slot = slot;
    s.req.period = period;
    s.req.start_stamp = stamp;
    s.gap = pick_gap(quiet);
    s.drain = drain;
    request_q.push_back(s);
  endtask

  initial begin
    int unsigned roll;
    logic [2:0] op;
    logic [2:0] slot;
    bit quiet;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_active[i] = 1'b0;
      slot_start[i] = '0;
      slot_period[i] = '0;
    end
    foreach (op_count[i]) op_count[i] = 0;

    // Directed part: check edges, filling the bank, multiple expiries,
    // range errors, update of a freed slot and the spare codes.
    add_request(stsb_pkg::OP_CHECK, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_CHECK, 3'd0, 32'd0, AllOnes, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_CHECK, 3'd7, AllOnes, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_REGISTER, 3'd6, 32'd0, 32'd0, 1'b1, 1'b0);
    add_request(stsb_pkg::OP_REGISTER, 3'd0, 32'd1, 32'd0, 1'b1, 1'b0);
    add_request(stsb_pkg::OP_REGISTER, 3'd0, AllOnes, 32'd0, 1'b1, 1'b0);
    add_request(stsb_pkg::OP_REGISTER, 3'd0, 32'd0, 32'd0, 1'b1, 1'b0);
    add_request(stsb_pkg::OP_REGISTER, 3'd0, 32'd3, 32'd0, 1'b1, 1'b0);
    add_request(stsb_pkg::OP_REGISTER, 3'd0, 32'd5, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 1'b1, 1'b0);
    add_request(stsb_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 1'b1, 1'b0);
    add_request(stsb_pkg::OP_UNREGISTER, 3'd7, 32'd0, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_UPDATE, 3'd5, AllOnes, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_UNREGISTER, 3'd4, 32'd0, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_UPDATE, 3'd4, 32'd0, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_UPDATE, 3'd1, AllOnes, AllOnes, 1'b0, 1'b0);
    add_request(OpSpareLo, 3'd2, AllOnes, AllOnes, 1'b0, 1'b0);
    add_request(OpSpareHi, 3'd7, 32'd0, 32'd0, 1'b0, 1'b0);
    add_request(stsb_pkg::OP_UNREGISTER, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
    add_request(stsb_pkg::OP_REGISTER, 3'd0, 32'd2, 32'd0, 1'b0, 1'b0);
    for (int k = 0; k < 3; k++) begin
      add_request(stsb_pkg::OP_TICK, 3'd0, 32'd0, 32'd0, 1'b1, 1'b0);
    end

    // Random part: ticks most often, against a busy bank, with every other
    // operation mixed in and now and then a pause for all results.
    for (int k = 0; k < RandomRequests; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) op = stsb_pkg::OP_TICK;
      else if (roll < 60) op = stsb_pkg::OP_REGISTER;
      else if (roll < 72) op = stsb_pkg::OP_UNREGISTER;
      else if (roll < 84) op = stsb_pkg::OP_UPDATE;
      else if (roll < 96) op = stsb_pkg::OP_CHECK;
      else op = 3'($urandom_range(OpSpareLo, OpSpareHi));
      slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NUM_SLOTS, 7))
                                         : 3'($urandom_range(0, NUM_SLOTS - 1));
      quiet = ((k / 40) % 3 == 2);
      add_request(op, slot, pick_period(), pick_stamp(), quiet, (k % 70 == 69));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || holding || start) @(negedge clk_i);
    while (rsp_due_q.size() != 0) @(negedge clk_i);
    repeat (NUM_SLOTS + 4) @(negedge clk_i);
    if (rsp_due_q.size() != 0) begin
      report_mismatch("results never seen", 32'(rsp_due_q.size()), '0);
    end

    $display("Ran %0d ticks, %0d registers, %0d unregisters, %0d updates, %0d checks",
             op_count[stsb_pkg::OP_TICK], op_count[stsb_pkg::OP_REGISTER],
             op_count[stsb_pkg::OP_UNREGISTER], op_count[stsb_pkg::OP_UPDATE],
             op_count[stsb_pkg::OP_CHECK]);
    $display("plus %0d spare codes; %0d slot expiries, %0d results, %0d mismatches",
             op_count[5] + op_count[6] + op_count[7], fired_total, results_seen,
             error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
